// ----- hw/rtl/dlvs_pkg.sv -----
// Shared widths, function codes, register indexes and colour tables of the dirty-line scanout.
package dlvs_pkg;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int COL_W    = 7;
  localparam int ROWF_W   = 6;
  localparam int PIX_W    = 2;
  localparam int ADDR_W   = 13;
  localparam int COLOR_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Geometry that does not vary
  localparam int MEM_COLUMNS   = 128;
  localparam int ROW_BITS      = PIX_W * MEM_COLUMNS;
  localparam int WINDOW_ORIGIN = 4;
  localparam int PAIR_W        = 8;

  // Palette select: bit 1 of pixels 125 and 126
  localparam int PAL_LO_BIT = PIX_W * 125 + 1;
  localparam int PAL_HI_BIT = PIX_W * 126 + 1;

  // Function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RENDER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_FRAME   = 2'd1;

  // Row memory command
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  localparam logic [COLOR_W-1:0] RGB565_LUT [4][4] = '{
    '{16'h066B, 16'hF98A, 16'h49FE, 16'h97F4},
    '{16'h066B, 16'hF98A, 16'h49FE, 16'hE71C},
    '{16'h066B, 16'hF98A, 16'h49FE, 16'hCE9F},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}
  };

  localparam logic [COLOR_W-1:0] RGB5551_LUT [4][4] = '{
    '{16'h0657, 16'hF995, 16'h49FD, 16'h97E9},
    '{16'h0657, 16'hF995, 16'h49FD, 16'hE739},
    '{16'h0657, 16'hF995, 16'h49FD, 16'hCEBF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001}
  };

  // Map a pixel through the selected palette and colour format
  function automatic logic [COLOR_W-1:0] color_lookup(input logic fmt,
                                                      input logic [1:0] pal,
                                                      input logic [PIX_W-1:0] pix);
    logic [COLOR_W-1:0] c;
    if (fmt) begin
      c = RGB5551_LUT[pal][pix];
    end else begin
      c = RGB565_LUT[pal][pix];
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/dlvs_ifs.sv -----
// Handshake channel interfaces for the input, result and configuration words.
interface dlvs_in_if import dlvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [COL_W-1:0]  column;
  logic [ROWF_W-1:0] row;
  logic [PIX_W-1:0]  pixel_value;

  modport source (output valid, func, column, row, pixel_value, input ready);
  modport sink   (input valid, func, column, row, pixel_value, output ready);
endinterface

interface dlvs_out_if import dlvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] color_first;
  logic [COLOR_W-1:0] color_second;
  logic               drawn;
  logic               last;

  modport source (output valid, pixel_address, color_first, color_second, drawn, last,
                  input ready);
  modport sink   (input valid, pixel_address, color_first, color_second, drawn, last,
                  output ready);
endinterface

interface dlvs_cfg_if import dlvs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/dlvs_line_mem.sv -----
// Row-wide video memory with registered read and per-row written flags.
module dlvs_line_mem import dlvs_pkg::*; #(
  parameter int ROWS = 64,
  parameter int AW   = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mem_cmd_t            cmd,
  input  logic [AW-1:0]       addr,
  input  logic [ROW_BITS-1:0] wr_data,
  output logic [ROW_BITS-1:0] rd_data
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     row_written_r;
  logic [ROW_BITS-1:0] rd_q_r;
  logic                rd_hit_r;

  // Store and fetch whole rows
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_q_r <= mem[addr];
    end
  end

  // Track rows written since reset; others read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_written_r <= '0;
      rd_hit_r      <= 1'b0;
    end else begin
      if (cmd.wr) begin
        row_written_r[addr] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_hit_r <= row_written_r[addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : '0;

endmodule

// ----- hw/rtl/dirty_line_vram_scanout.sv -----
// Top level of the dirty-line video memory with per-line colour scanout.
//
// A write word reads the row, then writes back the modified row; a mark-all word is taken
// straight from idle; a render word of a clean or hidden line gives one result; a render
// word of a dirty line fetches the row, then gives one result per colour pair (64 pairs in
// full mode, ceil(VISIBLE_COLUMNS/2) in cropped mode), each waiting for the result register
// to be free. One word is worked at a time, paced by the single row-wide memory port, read
// at most once per word, and by the result register, one pair per cycle while it is free.
// Rows never written since reset read as zero and the dirty bits clear at reset, so the
// block is ready straight after reset with no clearing pass.
module dirty_line_vram_scanout import dlvs_pkg::*; #(
  parameter int MEM_ROWS        = 64,
  parameter int VISIBLE_COLUMNS = 102,
  parameter int VISIBLE_ROWS    = 58
) (
  input logic         clk,
  input logic         rst_n,
  dlvs_cfg_if.sink    cfg_ch,
  dlvs_in_if.sink     in_ch,
  dlvs_out_if.source  out_ch
);

  localparam int ROW_AW = $clog2(MEM_ROWS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_CLEAN = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic                color_format_r;
  logic                full_frame_r;
  logic [MEM_ROWS-1:0] dirty_r;

  logic [ROWF_W-1:0]   row_r;
  logic [COL_W-1:0]    col_r;
  logic [PIX_W-1:0]    val_r;
  logic [ROW_BITS-1:0] line_r;
  logic [1:0]          pal_r;
  logic [ADDR_W-1:0]   base_r;
  logic [PAIR_W-1:0]   width_r;
  logic [PAIR_W-1:0]   pair_col_r;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [COLOR_W-1:0]  out_c1_r;
  logic [COLOR_W-1:0]  out_c2_r;
  logic                out_drawn_r;
  logic                out_last_r;

  mem_cmd_t            mem_cmd;
  logic [ROW_AW-1:0]   mem_addr;
  logic [ROW_BITS-1:0] mem_rd;
  logic [ROW_BITS-1:0] mem_wr;

  logic                in_fire;
  logic                row_ok;
  logic                dirty_hit;
  logic                in_window;
  logic                out_free;
  logic                pair_last;
  logic                pair_second;
  logic                emit_fire;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_format_r <= 1'b0;
      full_frame_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_COLOR_FORMAT: color_format_r <= cfg_ch.data;
        CFG_FULL_FRAME:   full_frame_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Decode the incoming word
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign row_ok      = int'(in_ch.row) < MEM_ROWS;
  assign dirty_hit   = row_ok && dirty_r[in_ch.row[ROW_AW-1:0]];
  assign in_window   = full_frame_r ||
                       (int'(in_ch.row) >= WINDOW_ORIGIN &&
                        int'(in_ch.row) < WINDOW_ORIGIN + VISIBLE_ROWS);

  // Pair position within the line
  assign out_free    = !out_valid_r || out_ch.ready;
  assign pair_last   = PAIR_W'(pair_col_r + PAIR_W'(2)) >= width_r;
  assign pair_second = PAIR_W'(pair_col_r + PAIR_W'(1)) < width_r;
  assign emit_fire   = (state_r == ST_EMIT) && out_free;

  // Sequence one word at a time
  always_comb begin
    state_nxt = state_r;
    mem_cmd   = '0;
    mem_addr  = row_r[ROW_AW-1:0];
    mem_wr    = mem_rd;
    mem_wr[{col_r, 1'b0} +: PIX_W] = val_r;
    unique case (state_r)
      ST_IDLE: begin
        mem_addr = in_ch.row[ROW_AW-1:0];
        if (in_fire) begin
          unique case (in_ch.func)
            FUNC_WRITE: begin
              if (row_ok) begin
                mem_cmd.rd = 1'b1;
                state_nxt  = ST_WRITE;
              end
            end
            FUNC_RENDER: begin
              if (dirty_hit && in_window) begin
                mem_cmd.rd = 1'b1;
                state_nxt  = ST_FETCH;
              end else begin
                state_nxt  = ST_CLEAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        mem_cmd.wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FETCH: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire && pair_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Dirty bits: mark all, set on write, drop after the last pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= '0;
    end else begin
      if (in_fire && in_ch.func == FUNC_MARK) begin
        dirty_r <= '1;
      end
      if (state_r == ST_WRITE) begin
        dirty_r[row_r[ROW_AW-1:0]] <= 1'b1;
      end
      if (emit_fire && pair_last) begin
        dirty_r[row_r[ROW_AW-1:0]] <= 1'b0;
      end
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= in_ch.row;
      col_r <= in_ch.column;
      val_r <= in_ch.pixel_value;
    end
  end

  // Load the line, palette and base address; advance one pair per result
  always_ff @(posedge clk) begin
    if (state_r == ST_FETCH) begin
      pal_r      <= {mem_rd[PAL_HI_BIT], mem_rd[PAL_LO_BIT]};
      pair_col_r <= '0;
      if (full_frame_r) begin
        line_r  <= mem_rd;
        width_r <= PAIR_W'(MEM_COLUMNS);
        base_r  <= ADDR_W'(ADDR_W'(row_r) << $clog2(MEM_COLUMNS));
      end else begin
        line_r  <= mem_rd >> (PIX_W * WINDOW_ORIGIN);
        width_r <= PAIR_W'(VISIBLE_COLUMNS);
        base_r  <= ADDR_W'((ADDR_W'(row_r) - ADDR_W'(WINDOW_ORIGIN)) *
                           ADDR_W'(VISIBLE_COLUMNS));
      end
    end else if (emit_fire) begin
      line_r     <= line_r >> (2 * PIX_W);
      pair_col_r <= PAIR_W'(pair_col_r + PAIR_W'(2));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT || state_r == ST_CLEAN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_addr_r  <= ADDR_W'(base_r + ADDR_W'(pair_col_r));
      out_c1_r    <= color_lookup(color_format_r, pal_r, line_r[PIX_W-1:0]);
      out_c2_r    <= pair_second ?
                     color_lookup(color_format_r, pal_r, line_r[2*PIX_W-1:PIX_W]) : '0;
      out_drawn_r <= 1'b1;
      out_last_r  <= pair_last;
    end else if (state_r == ST_CLEAN && out_free) begin
      out_addr_r  <= '0;
      out_c1_r    <= '0;
      out_c2_r    <= '0;
      out_drawn_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.color_first   = out_c1_r;
  assign out_ch.color_second  = out_c2_r;
  assign out_ch.drawn         = out_drawn_r;
  assign out_ch.last          = out_last_r;

  dlvs_line_mem #(
    .ROWS (MEM_ROWS),
    .AW   (ROW_AW)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mem_cmd),
    .addr    (mem_addr),
    .wr_data (mem_wr),
    .rd_data (mem_rd)
  );

  // Write-back always follows the read of the same row
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cmd.wr |-> $past(mem_cmd.rd))
    else $error("row write-back without a preceding read");

  // The last pair of a line leaves that row clean
  a_dirty_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && pair_last) |=> !dirty_r[row_r[ROW_AW-1:0]])
    else $error("dirty bit not cleared after line scanout");

  // No new word while a line is still part-delivered
  a_no_accept_midline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> !in_ch.ready)
    else $error("input accepted during line scanout");

  // Pair column stays even and inside the line
  a_pair_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (!pair_col_r[0] && pair_col_r < width_r))
    else $error("pair column out of step");

endmodule
